@@ sv/vrt_pkg.sv @@
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned MaxSteps = 64;
  localparam logic [15:0] MaxDistReset = 16'd2560;
  localparam logic [23:0] TInf = 24'hFFFFFF;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpCast = 2'd2;

  localparam logic [1:0] StMiss = 2'd0;
  localparam logic [1:0] StHit = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  localparam logic [2:0] FaceLeft = 3'd0;
  localparam logic [2:0] FaceRight = 3'd1;
  localparam logic [2:0] FaceTop = 3'd2;
  localparam logic [2:0] FaceBottom = 3'd3;
  localparam logic [2:0] FaceFront = 3'd4;
  localparam logic [2:0] FaceBack = 3'd5;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request, start setup
    logic div_start;  // start division
    logic div_sel_delta;  // 0: first boundary, 1: tDelta
    logic [1:0] div_axis;
    logic div_store;  // store quotient
    logic scan_start; // begin table scan of current cell
    logic scan_next;  // advance scan address
    logic step;       // take one DDA step
    logic ins_write;  // write cell into table
    logic clr;        // empty table
    logic res_load;   // latch result
    logic [1:0] res_status;
  } vrt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic scan_hit;
    logic scan_end;
    logic full;
    logic walk_end;   // distance reached limit
  } vrt_sts_t;
endpackage

@@ sv/voxel_ray_traversal_hit.sv @@
// Voxel ray traversal: table of occupied cells and a 3D DDA ray walk.
// Sequence: table ops give their result in the next cycle; a ray runs six divisions of
// setup on the shared bit-serial divider, then per tested cell a table scan
// of one entry a cycle, up to MaxSteps cells.
// Throughput: one request at a time; the next is taken once the result leaves.
// Reset (rst_ni low, async): table empty, max_distance = 10.0, no result.
module voxel_ray_traversal_hit #(
  parameter int unsigned TableDepth = vrt_pkg::TableDepth,
  parameter int unsigned MaxSteps = vrt_pkg::MaxSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], cell_x/y/z[49:2], origin_x/y/z[121:50], dir_x/y/z[169:122], zero pad
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], hit_x/y/z[49:2], hit_face[52:50], zero pad
  output logic [55:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);
  logic [15:0] max_distance_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_distance_q <= vrt_pkg::MaxDistReset;
    end else if (cfg_we_i) begin
      max_distance_q <= cfg_wdata_i;
    end
  end

  vrt_pkg::vrt_cmd_t cmd;
  vrt_pkg::vrt_sts_t sts;
  logic [1:0] status;
  logic [15:0] hx, hy, hz;
  logic [2:0] hf;

  vrt_ctrl #(.MaxSteps(MaxSteps)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tdata[1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vrt_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .max_distance_i (max_distance_q),
    .cell_x_i   (s_axis_tdata[17:2]),
    .cell_y_i   (s_axis_tdata[33:18]),
    .cell_z_i   (s_axis_tdata[49:34]),
    .origin_x_i (s_axis_tdata[73:50]),
    .origin_y_i (s_axis_tdata[97:74]),
    .origin_z_i (s_axis_tdata[121:98]),
    .dir_x_i    (s_axis_tdata[137:122]),
    .dir_y_i    (s_axis_tdata[153:138]),
    .dir_z_i    (s_axis_tdata[169:154]),
    .status_o   (status),
    .hit_x_o    (hx),
    .hit_y_o    (hy),
    .hit_z_o    (hz),
    .hit_face_o (hf)
  );

  assign m_axis_tdata = {3'd0, hf, hz, hy, hx, status};
endmodule

@@ sv/vrt_div.sv @@
// Restoring divider, one quotient bit per cycle, saturated to 24 bits.
module vrt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [23:0] quo_o
);
  logic [31:0] q_q, q_d;
  logic [15:0] r_q, r_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        fin_q;
  logic [16:0] tr;
  logic [16:0] diff;
  logic [16:0] den17;

  assign den17 = {1'b0, den_i};

  // remainder stays below den (at most 2^15), so it fits 16 bits
  always_comb begin
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    tr = {r_q, q_q[31]};
    diff = tr - den17;
    if (start_i) begin
      q_d = num_i;
      r_d = '0;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (tr >= den17) begin
        r_d = diff[15:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = tr[15:0];
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  // done pulses once, right after the last shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      fin_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      fin_q <= busy_q && (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end

  assign done_o = fin_q;
  assign quo_o = (q_q[31:24] != 8'd0) ? 24'hFFFFFF : q_q[23:0];
endmodule

@@ sv/vrt_datapath.sv @@
// Ray setup, DDA stepping, cell table and result registers.
module vrt_datapath #(
  parameter int unsigned TableDepth = vrt_pkg::TableDepth,
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CW = $clog2(TableDepth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrt_pkg::vrt_cmd_t  cmd_i,
  output vrt_pkg::vrt_sts_t  sts_o,
  input  logic [15:0]        max_distance_i,
  input  logic [15:0]        cell_x_i,
  input  logic [15:0]        cell_y_i,
  input  logic [15:0]        cell_z_i,
  input  logic [23:0]        origin_x_i,
  input  logic [23:0]        origin_y_i,
  input  logic [23:0]        origin_z_i,
  input  logic [15:0]        dir_x_i,
  input  logic [15:0]        dir_y_i,
  input  logic [15:0]        dir_z_i,
  output logic [1:0]         status_o,
  output logic [15:0]        hit_x_o,
  output logic [15:0]        hit_y_o,
  output logic [15:0]        hit_z_o,
  output logic [2:0]         hit_face_o
);
  logic [47:0] mem_q [TableDepth];
  logic [47:0] rd_q;
  logic        rd_vld_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] addr_q;

  logic [15:0] c_q [3];
  logic [23:0] t_q [3];
  logic [23:0] dt_q [3];
  logic [15:0] mag_q [3];
  logic [8:0]  dist8_q [3];
  logic        neg_q [3];
  logic        zero_q [3];
  logic [23:0] dist_q;
  logic [2:0]  face_q;

  logic        div_done;
  logic [23:0] quo;
  logic [31:0] num;
  logic [15:0] den;

  // axis operand mux for the shared divider
  always_comb begin
    den = mag_q[cmd_i.div_axis];
    if (cmd_i.div_sel_delta) begin
      num = 32'h4000_0000;
    end else begin
      num = {1'b0, dist8_q[cmd_i.div_axis], 22'd0};
    end
  end

  vrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // axis choice: x if tx<ty and tx<tz, else y if ty<tz, else z
  logic [1:0] ax;
  always_comb begin
    if (t_q[0] < t_q[1] && t_q[0] < t_q[2]) begin
      ax = 2'd0;
    end else if (t_q[1] < t_q[2]) begin
      ax = 2'd1;
    end else begin
      ax = 2'd2;
    end
  end

  logic [24:0] tsum;
  assign tsum = {1'b0, t_q[ax]} + {1'b0, dt_q[ax]};

  logic [23:0] org [3];
  logic [15:0] dir [3];
  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  // boundary gap in Q.8: frac for a negative step, 256-frac for a positive one
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= org[i][23:8];
        zero_q[i] <= (dir[i] == 16'd0);
        neg_q[i] <= dir[i][15];
        mag_q[i] <= dir[i][15] ? (16'd0 - dir[i]) : dir[i];
        dist8_q[i] <= dir[i][15] ? {1'b0, org[i][7:0]} : (9'd256 - {1'b0, org[i][7:0]});
        t_q[i] <= vrt_pkg::TInf;
        dt_q[i] <= vrt_pkg::TInf;
      end
      dist_q <= '0;
      face_q <= vrt_pkg::FaceFront;
    end else if (cmd_i.div_store) begin
      if (!zero_q[cmd_i.div_axis]) begin
        if (cmd_i.div_sel_delta) begin
          dt_q[cmd_i.div_axis] <= quo;
        end else begin
          t_q[cmd_i.div_axis] <= quo;
        end
      end
    end else if (cmd_i.step) begin
      dist_q <= t_q[ax];
      t_q[ax] <= (tsum[24] || t_q[ax] == vrt_pkg::TInf) ? vrt_pkg::TInf : tsum[23:0];
      if (!zero_q[ax]) begin
        c_q[ax] <= neg_q[ax] ? c_q[ax] - 16'd1 : c_q[ax] + 16'd1;
      end
      unique case (ax)
        2'd0: face_q <= (!zero_q[0] && !neg_q[0]) ? vrt_pkg::FaceLeft : vrt_pkg::FaceRight;
        2'd1: face_q <= (!zero_q[1] && !neg_q[1]) ? vrt_pkg::FaceBottom : vrt_pkg::FaceTop;
        default: face_q <= (!zero_q[2] && !neg_q[2]) ? vrt_pkg::FaceBack : vrt_pkg::FaceFront;
      endcase
    end
  end

  // cell table, scanned one entry per cycle
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  assign waddr = count_q[AW-1:0];
  assign raddr = addr_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_write && count_q < CW'(TableDepth)) begin
      mem_q[waddr] <= {cell_z_i, cell_y_i, cell_x_i};
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      addr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        count_q <= '0;
      end else if (cmd_i.ins_write && count_q < CW'(TableDepth)) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.scan_start) begin
        addr_q <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan_next) begin
        addr_q <= addr_q + CW'(1);
        rd_vld_q <= (addr_q < count_q);
      end
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.scan_hit = rd_vld_q && (rd_q == {c_q[2], c_q[1], c_q[0]});
  assign sts_o.scan_end = (addr_q >= count_q) && !rd_vld_q;
  assign sts_o.full = (count_q >= CW'(TableDepth));
  // a zero limit ends the walk at once, since the distance starts at zero
  assign sts_o.walk_end = (dist_q >= {max_distance_i, 8'd0});

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_o <= cmd_i.res_status;
      if (cmd_i.res_status == vrt_pkg::StHit) begin
        hit_x_o <= c_q[0];
        hit_y_o <= c_q[1];
        hit_z_o <= c_q[2];
        hit_face_o <= face_q;
      end else begin
        hit_x_o <= '0;
        hit_y_o <= '0;
        hit_z_o <= '0;
        hit_face_o <= vrt_pkg::FaceFront;
      end
    end
  end
endmodule

@@ sv/vrt_ctrl.sv @@
// Sequencer for table ops, divider setup and the DDA walk.
module vrt_ctrl #(
  parameter int unsigned MaxSteps = vrt_pkg::MaxSteps,
  localparam int unsigned SW = $clog2(MaxSteps + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vrt_pkg::vrt_cmd_t cmd_o,
  input  vrt_pkg::vrt_sts_t sts_i
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_WAIT = 7'b0000100,
    S_TEST = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_STEP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] job_q, job_d;
  logic [SW-1:0] n_q, n_d;
  logic vld_q, vld_d;

  assign out_valid_o = vld_q;
  assign in_ready_o = (state_q == S_IDLE) && !vld_q;

  always_comb begin
    state_d = state_q;
    job_d = job_q;
    n_d = n_q;
    vld_d = vld_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.div_axis = job_q[2:1];
    cmd_o.div_sel_delta = job_q[0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_status = vrt_pkg::StDone;
          case (opcode_i)
            vrt_pkg::OpClear: begin
              cmd_o.clr = 1'b1;
              vld_d = 1'b1;
            end
            vrt_pkg::OpInsert: begin
              cmd_o.ins_write = 1'b1;
              if (sts_i.full) cmd_o.res_status = vrt_pkg::StFull;
              vld_d = 1'b1;
            end
            vrt_pkg::OpCast: begin
              cmd_o.res_load = 1'b0;
              cmd_o.load = 1'b1;
              job_d = '0;
              n_d = '0;
              state_d = S_DIV;
            end
            default: vld_d = 1'b1;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (job_q == 3'd5) begin
            state_d = S_TEST;
          end else begin
            job_d = job_q + 3'd1;
            state_d = S_DIV;
          end
        end
      end
      S_TEST: begin
        if (n_q == SW'(MaxSteps) || sts_i.walk_end) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_status = vrt_pkg::StMiss;
          state_d = S_OUT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_next = 1'b1;
        if (sts_i.scan_hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_status = vrt_pkg::StHit;
          state_d = S_OUT;
        end else if (sts_i.scan_end) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        n_d = n_q + SW'(1);
        state_d = S_TEST;
      end
      S_OUT: begin
        vld_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q <= '0;
      n_q <= '0;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q <= job_d;
      n_q <= n_d;
      vld_q <= vld_d;
    end
  end
endmodule
